// ===== sv/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants of the HSV to RGB converter
// Payload structs of both channels, the structs handed between pipeline
// stages, and the fixed-point constants of the conversion.
// ----------------------------------------------------------------------------
package hsv_pkg;

   localparam int unsigned HueWidth    = 13;
   localparam int unsigned LevelWidth  = 8;
   localparam int unsigned SectorUnits = 960;
   localparam int unsigned FullLevel   = 255;
   localparam int unsigned FracScale   = FullLevel * SectorUnits;

   // Highest sector index that a hue word can reach, and the widths that follow.
   localparam int unsigned SectorSteps = ((1 << HueWidth) - 1) / SectorUnits;
   localparam int unsigned SectorWidth = $clog2(SectorSteps + 1);
   localparam int unsigned FracWidth   = $clog2(SectorUnits);
   localparam int unsigned ProdWidth   = $clog2(FracScale + 1);
   localparam int unsigned PNumWidth   = 2 * LevelWidth;
   localparam int unsigned NumWidth    = LevelWidth + ProdWidth;

   // Reciprocal multipliers: floor(2^shift / divisor), estimate low by at most one.
   localparam int unsigned PShift  = PNumWidth;
   localparam int unsigned PRecip  = (1 << PShift) / FullLevel;
   localparam int unsigned PRecipW = $clog2(PRecip + 1);
   localparam int unsigned QShift  = NumWidth;
   localparam int unsigned QRecip  = (1 << QShift) / FracScale;
   localparam int unsigned QRecipW = $clog2(QRecip + 1);

   // Sector codes; anything above the last one takes the magenta to red selection.
   localparam logic [SectorWidth-1:0] SectorRedYellow   = SectorWidth'(0);
   localparam logic [SectorWidth-1:0] SectorYellowGreen = SectorWidth'(1);
   localparam logic [SectorWidth-1:0] SectorGreenCyan   = SectorWidth'(2);
   localparam logic [SectorWidth-1:0] SectorCyanBlue    = SectorWidth'(3);
   localparam logic [SectorWidth-1:0] SectorBlueMagenta = SectorWidth'(4);

   typedef struct packed {
      logic [HueWidth-1:0]   hue_sixteenths;
      logic [LevelWidth-1:0] sat_level;
      logic [LevelWidth-1:0] val_level;
   } hsv_req_type;

   typedef struct packed {
      logic [LevelWidth-1:0] red_out;
      logic [LevelWidth-1:0] green_out;
      logic [LevelWidth-1:0] blue_out;
   } hsv_rsp_type;

   typedef struct packed {
      logic [SectorWidth-1:0] sector;
      logic [FracWidth-1:0]   frac;
      logic [LevelWidth-1:0]  sat_level;
      logic [LevelWidth-1:0]  val_level;
   } hsv_sect_type;

   typedef struct packed {
      logic [SectorWidth-1:0] sector;
      logic [LevelWidth-1:0]  val_level;
      logic [PNumWidth-1:0]   p_num;
      logic [ProdWidth-1:0]   sf_q;
      logic [ProdWidth-1:0]   sf_t;
   } hsv_prod_type;

   typedef struct packed {
      logic [SectorWidth-1:0] sector;
      logic [LevelWidth-1:0]  val_level;
      logic [PNumWidth-1:0]   p_num;
      logic [NumWidth-1:0]    q_num;
      logic [NumWidth-1:0]    t_num;
   } hsv_num_type;

   typedef struct packed {
      logic [SectorWidth-1:0] sector;
      logic [LevelWidth-1:0]  val_level;
      logic [PNumWidth-1:0]   p_num;
      logic [NumWidth-1:0]    q_num;
      logic [NumWidth-1:0]    t_num;
      logic [LevelWidth-1:0]  p_est;
      logic [LevelWidth-1:0]  q_est;
      logic [LevelWidth-1:0]  t_est;
   } hsv_est_type;

   typedef struct packed {
      logic [SectorWidth-1:0] sector;
      logic [LevelWidth-1:0]  val_level;
      logic [LevelWidth-1:0]  p_lvl;
      logic [LevelWidth-1:0]  q_lvl;
      logic [LevelWidth-1:0]  t_lvl;
   } hsv_lvl_type;

endpackage

// ===== sv/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: HSV to 8-bit RGB pixel converter
// Six-stage pipeline from HSV pixels to RGB: one per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel per transfer: hue in 1/16 degree, saturation and
//   value as 8-bit levels (255 is full scale). rsp_* returns the RGB triple.
//   A transfer happens on a rising edge with valid high and stall low.
//   A pixel moves through the stages in order to the output register.
//   Throughput is one pixel per clock unless stalled; a stage takes a new
//   pixel whenever it is empty or its pixel moves on. The six register
//   stages are: hue split, two multiply stages, reciprocal estimate,
//   correction and the channel select into the output register.
//   Zero saturation needs no special path: p, q and t all equal the value.
//   Hue of 360 degrees or beyond takes the last sector's channel selection.
//   Reset (synchronous, active high) drops every item in flight and clears
//   all valid bits; payload registers keep whatever they held.
//   When the receiver stalls, the output register holds its pixel; stages
//   upstream keep advancing into empty slots, so bubbles close up and
//   req_stall rises only once every stage holds a pixel.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  hsv_pkg::hsv_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hsv_pkg::hsv_rsp_type rsp_data
);
   import hsv_pkg::*;

   // Handshake between stages: valid forward, ready back.
   logic         sect_valid;
   logic         sect_ready;
   hsv_sect_type sect_data;
   logic         num_valid;
   logic         num_ready;
   hsv_num_type  num_data;
   logic         lvl_valid;
   logic         lvl_ready;
   hsv_lvl_type  lvl_data;
   logic         req_ready;

   // Split the hue into sector and fraction.
   hsv_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (sect_valid),
      .out_ready (sect_ready),
      .out_data  (sect_data)
   );

   // Form the numerators of p, q and t.
   hsv_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sect_valid),
      .in_ready  (sect_ready),
      .in_data   (sect_data),
      .out_valid (num_valid),
      .out_ready (num_ready),
      .out_data  (num_data)
   );

   // Divide by the constant scales, truncating toward zero.
   hsv_cdiv u_cdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .in_data   (num_data),
      .out_valid (lvl_valid),
      .out_ready (lvl_ready),
      .out_data  (lvl_data)
   );

   // Route the levels to the channels and hold the result for the receiver.
   hsv_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lvl_valid),
      .in_ready  (lvl_ready),
      .in_data   (lvl_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = !req_ready;

endmodule

// ===== sv/hsv_sector.sv =====
// ----------------------------------------------------------------------------
// hsv_sector: hue split stage
// Splits the hue into a sector index and a fraction within the sector.
// ----------------------------------------------------------------------------
module hsv_sector (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsv_pkg::hsv_req_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsv_pkg::hsv_sect_type out_data
);
   import hsv_pkg::*;

   logic [SectorSteps-1:0] ge;
   logic [HueWidth-1:0]    base;
   hsv_sect_type           sect_in;
   hsv_sect_type           sect_ff;
   logic                   vld_ff;

   // Independent compares against each sector boundary; the last hit is the base.
   always_comb begin
      base = '0;
      for (int k = 1; k <= SectorSteps; k++) begin
         ge[k-1] = in_data.hue_sixteenths >= HueWidth'(k * SectorUnits);
         if (ge[k-1]) begin
            base = HueWidth'(k * SectorUnits);
         end
      end
      sect_in.sector    = SectorWidth'($countones(ge));
      sect_in.frac      = FracWidth'(in_data.hue_sixteenths - base);
      sect_in.sat_level = in_data.sat_level;
      sect_in.val_level = in_data.val_level;
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         sect_ff <= sect_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = sect_ff;

endmodule

// ===== sv/hsv_mult.sv =====
// ----------------------------------------------------------------------------
// hsv_mult: numerator stages
// Two multiply stages that form the numerators of p, q and t.
// ----------------------------------------------------------------------------
module hsv_mult (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsv_pkg::hsv_sect_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsv_pkg::hsv_num_type  out_data
);
   import hsv_pkg::*;

   logic [FracWidth-1:0] frac_rest;
   hsv_prod_type         prod_in;
   hsv_prod_type         prod_ff;
   logic                 prod_vld_ff;
   logic                 prod_ready;
   hsv_num_type          num_in;
   hsv_num_type          num_ff;
   logic                 num_vld_ff;

   // Stage one: saturation times fraction and its complement, and p's numerator.
   always_comb begin
      frac_rest         = FracWidth'(SectorUnits) - in_data.frac;
      prod_in.sector    = in_data.sector;
      prod_in.val_level = in_data.val_level;
      prod_in.p_num     = PNumWidth'(in_data.val_level) *
                          PNumWidth'(LevelWidth'(FullLevel) - in_data.sat_level);
      prod_in.sf_q      = ProdWidth'(in_data.sat_level) * ProdWidth'(in_data.frac);
      prod_in.sf_t      = ProdWidth'(in_data.sat_level) * ProdWidth'(frac_rest);
   end

   // Stage two: value times the scaled remainders.
   always_comb begin
      num_in.sector    = prod_ff.sector;
      num_in.val_level = prod_ff.val_level;
      num_in.p_num     = prod_ff.p_num;
      num_in.q_num     = NumWidth'(prod_ff.val_level) *
                         NumWidth'(ProdWidth'(FracScale) - prod_ff.sf_q);
      num_in.t_num     = NumWidth'(prod_ff.val_level) *
                         NumWidth'(ProdWidth'(FracScale) - prod_ff.sf_t);
   end

   assign prod_ready = !num_vld_ff || out_ready;
   assign in_ready   = !prod_vld_ff || prod_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         num_vld_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            prod_vld_ff <= in_valid;
         end
         if (prod_ready) begin
            num_vld_ff <= prod_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (prod_ready && prod_vld_ff) begin
         num_ff <= num_in;
      end
   end

   assign out_valid = num_vld_ff;
   assign out_data  = num_ff;

endmodule

// ===== sv/hsv_cdiv.sv =====
// ----------------------------------------------------------------------------
// hsv_cdiv: constant divider stages
// Divides the numerators by constants: reciprocal estimate, then one correction.
// ----------------------------------------------------------------------------
module hsv_cdiv (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsv_pkg::hsv_num_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsv_pkg::hsv_lvl_type out_data
);
   import hsv_pkg::*;

   localparam int unsigned PProdW = PNumWidth + PRecipW;
   localparam int unsigned QProdW = NumWidth + QRecipW;

   logic [PProdW-1:0]    p_prod;
   logic [QProdW-1:0]    q_prod;
   logic [QProdW-1:0]    t_prod;
   hsv_est_type          est_in;
   hsv_est_type          est_ff;
   logic                 est_vld_ff;
   logic                 est_ready;
   logic [PNumWidth-1:0] p_rem;
   logic [NumWidth-1:0]  q_rem;
   logic [NumWidth-1:0]  t_rem;
   hsv_lvl_type          lvl_in;
   hsv_lvl_type          lvl_ff;
   logic                 lvl_vld_ff;

   // Estimate: multiply by the truncated reciprocal and drop the fraction bits.
   always_comb begin
      p_prod = PProdW'(in_data.p_num) * PProdW'(PRecip);
      q_prod = QProdW'(in_data.q_num) * QProdW'(QRecip);
      t_prod = QProdW'(in_data.t_num) * QProdW'(QRecip);
      est_in.sector    = in_data.sector;
      est_in.val_level = in_data.val_level;
      est_in.p_num     = in_data.p_num;
      est_in.q_num     = in_data.q_num;
      est_in.t_num     = in_data.t_num;
      est_in.p_est     = LevelWidth'(p_prod >> PShift);
      est_in.q_est     = LevelWidth'(q_prod >> QShift);
      est_in.t_est     = LevelWidth'(t_prod >> QShift);
   end

   // Correct: bump the estimate where the remainder still holds a whole divisor.
   always_comb begin
      p_rem = est_ff.p_num - PNumWidth'(est_ff.p_est) * PNumWidth'(FullLevel);
      q_rem = est_ff.q_num - NumWidth'(est_ff.q_est) * NumWidth'(FracScale);
      t_rem = est_ff.t_num - NumWidth'(est_ff.t_est) * NumWidth'(FracScale);
      lvl_in.sector    = est_ff.sector;
      lvl_in.val_level = est_ff.val_level;
      lvl_in.p_lvl     = est_ff.p_est + LevelWidth'(p_rem >= PNumWidth'(FullLevel));
      lvl_in.q_lvl     = est_ff.q_est + LevelWidth'(q_rem >= NumWidth'(FracScale));
      lvl_in.t_lvl     = est_ff.t_est + LevelWidth'(t_rem >= NumWidth'(FracScale));
   end

   assign est_ready = !lvl_vld_ff || out_ready;
   assign in_ready  = !est_vld_ff || est_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_vld_ff <= 1'b0;
         lvl_vld_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            est_vld_ff <= in_valid;
         end
         if (est_ready) begin
            lvl_vld_ff <= est_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         est_ff <= est_in;
      end
      if (est_ready && est_vld_ff) begin
         lvl_ff <= lvl_in;
      end
   end

   assign out_valid = lvl_vld_ff;
   assign out_data  = lvl_ff;

endmodule

// ===== sv/hsv_select.sv =====
// ----------------------------------------------------------------------------
// hsv_select: channel select and output register
// Routes v, p, q and t to red, green and blue by sector.
// ----------------------------------------------------------------------------
module hsv_select (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsv_pkg::hsv_lvl_type in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output hsv_pkg::hsv_rsp_type out_data
);
   import hsv_pkg::*;

   hsv_rsp_type rgb_in;
   hsv_rsp_type rgb_ff;
   logic        vld_ff;

   always_comb begin
      case (in_data.sector)
         SectorRedYellow: begin
            rgb_in = '{in_data.val_level, in_data.t_lvl, in_data.p_lvl};
         end
         SectorYellowGreen: begin
            rgb_in = '{in_data.q_lvl, in_data.val_level, in_data.p_lvl};
         end
         SectorGreenCyan: begin
            rgb_in = '{in_data.p_lvl, in_data.val_level, in_data.t_lvl};
         end
         SectorCyanBlue: begin
            rgb_in = '{in_data.p_lvl, in_data.q_lvl, in_data.val_level};
         end
         SectorBlueMagenta: begin
            rgb_in = '{in_data.t_lvl, in_data.p_lvl, in_data.val_level};
         end
         default: begin
            rgb_in = '{in_data.val_level, in_data.p_lvl, in_data.q_lvl};
         end
      endcase
   end

   assign in_ready = !vld_ff || !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rgb_ff <= rgb_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = rgb_ff;

endmodule

// ===== sv/hsv_checker.sv =====
// ----------------------------------------------------------------------------
// hsv_checker: port-level checks for the HSV to RGB converter
// Watches both channels over time; bound to the top level below.
// ----------------------------------------------------------------------------
module hsv_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input hsv_pkg::hsv_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input hsv_pkg::hsv_rsp_type rsp_data
);
   import hsv_pkg::*;

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A free receiver never backs up the request side.
   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // With the receiver free, a gray pixel comes out with the value on every channel.
   a_gray_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.sat_level == '0)
      ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid
          && rsp_data.red_out   == $past(req_data.val_level, 6)
          && rsp_data.green_out == $past(req_data.val_level, 6)
          && rsp_data.blue_out  == $past(req_data.val_level, 6))
      else $error("gray pixel wrong or late");

endmodule

bind hsv_to_rgb_converter hsv_checker u_checker (.*);

// ===== tb/sv/tb_hsv_to_rgb_converter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter: self-checking bench for the HSV to RGB converter
// Drives HSV pixels through the request channel and predicts every RGB
// triple with an independent integer model of the conversion. It compares each
// response transfer field by field, in order. Phases run corner pixels, free
// streaming, sender gaps, receiver stalls, gaps with stalls and a long output
// hold-off that backs the pipeline up into the request channel.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;
   import hsv_pkg::*;

   // Pixel in flight together with the RGB triple it must produce
   typedef struct {
      hsv_req_type pixel;
      hsv_rsp_type rgb;
   } pending_pixel_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   hsv_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   hsv_rsp_type rsp_data;

   pending_pixel_type pending_rgb[$];

   int error_count    = 0;
   int pixels_sent    = 0;
   int pixels_checked = 0;
   int blocked_cycles = 0;

   // Traffic shaping, owned by the stimulus process
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_len       = 0;
   int hold_id        = 0;

   hsv_to_rgb_converter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 2 ns clock: high half, then low half
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Exact integer form of the conversion: every quotient truncates, so p, q
   // and t never exceed the value level and no clipping is needed.
   function automatic hsv_rsp_type predict_rgb(input hsv_req_type px);
      int unsigned             sat;
      int unsigned             val;
      int unsigned             frac;
      int unsigned             p_lvl;
      int unsigned             q_lvl;
      int unsigned             t_lvl;
      logic [SectorWidth-1:0]  sector;
      hsv_rsp_type             rgb;
      sat    = px.sat_level;
      val    = px.val_level;
      sector = SectorWidth'(px.hue_sixteenths / SectorUnits);
      frac   = px.hue_sixteenths % SectorUnits;
      // Grey: zero saturation puts the value on every channel
      if (sat == 0) begin
         rgb.red_out   = LevelWidth'(val);
         rgb.green_out = LevelWidth'(val);
         rgb.blue_out  = LevelWidth'(val);
         return rgb;
      end
      p_lvl = (val * (FullLevel - sat)) / FullLevel;
      q_lvl = (val * (FracScale - sat * frac)) / FracScale;
      t_lvl = (val * (FracScale - sat * (SectorUnits - frac))) / FracScale;
      case (sector)
         SectorRedYellow: begin
            rgb = '{LevelWidth'(val), LevelWidth'(t_lvl), LevelWidth'(p_lvl)};
         end
         SectorYellowGreen: begin
            rgb = '{LevelWidth'(q_lvl), LevelWidth'(val), LevelWidth'(p_lvl)};
         end
         SectorGreenCyan: begin
            rgb = '{LevelWidth'(p_lvl), LevelWidth'(val), LevelWidth'(t_lvl)};
         end
         SectorCyanBlue: begin
            rgb = '{LevelWidth'(p_lvl), LevelWidth'(q_lvl), LevelWidth'(val)};
         end
         SectorBlueMagenta: begin
            rgb = '{LevelWidth'(t_lvl), LevelWidth'(p_lvl), LevelWidth'(val)};
         end
         // Magenta to red, hue at 360 degrees and anything past it land here
         default: begin
            rgb = '{LevelWidth'(val), LevelWidth'(p_lvl), LevelWidth'(q_lvl)};
         end
      endcase
      return rgb;
   endfunction

   function automatic hsv_req_type make_pixel(input int unsigned hue, input int unsigned sat,
                                              input int unsigned val);
      hsv_req_type px;
      px.hue_sixteenths = HueWidth'(hue);
      px.sat_level      = LevelWidth'(sat);
      px.val_level      = LevelWidth'(val);
      return px;
   endfunction

   // Mostly in-range hues, with weight on sector edges and on words past 360
   function automatic hsv_req_type random_pixel();
      int unsigned hue;
      int unsigned sat;
      int unsigned val;
      case ($urandom_range(9))
         0:       hue = $urandom_range((1 << HueWidth) - 1, 6 * SectorUnits + 1);
         1:       hue = $urandom_range(6, 1) * SectorUnits - 1 + $urandom_range(2);
         default: hue = $urandom_range(6 * SectorUnits);
      endcase
      case ($urandom_range(7))
         0:       sat = 0;
         1:       sat = FullLevel;
         default: sat = $urandom_range(FullLevel);
      endcase
      val = ($urandom_range(9) == 0) ? FullLevel : $urandom_range(FullLevel);
      return make_pixel(hue, sat, val);
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Compare every response transfer against the oldest pending pixel
   always @(posedge clock) begin
      pending_pixel_type head;
      if (!reset && req_valid && req_stall) begin
         blocked_cycles++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rgb.size() == 0) begin
            report_mismatch($sformatf("unexpected response r=%0d g=%0d b=%0d",
                                      rsp_data.red_out, rsp_data.green_out,
                                      rsp_data.blue_out));
         end else begin
            head = pending_rgb.pop_front();
            pixels_checked++;
            if (rsp_data.red_out !== head.rgb.red_out) begin
               report_mismatch($sformatf("red h=%0d s=%0d v=%0d: got %0d want %0d",
                                         head.pixel.hue_sixteenths, head.pixel.sat_level,
                                         head.pixel.val_level, rsp_data.red_out,
                                         head.rgb.red_out));
            end
            if (rsp_data.green_out !== head.rgb.green_out) begin
               report_mismatch($sformatf("green h=%0d s=%0d v=%0d: got %0d want %0d",
                                         head.pixel.hue_sixteenths, head.pixel.sat_level,
                                         head.pixel.val_level, rsp_data.green_out,
                                         head.rgb.green_out));
            end
            if (rsp_data.blue_out !== head.rgb.blue_out) begin
               report_mismatch($sformatf("blue h=%0d s=%0d v=%0d: got %0d want %0d",
                                         head.pixel.hue_sixteenths, head.pixel.sat_level,
                                         head.pixel.val_level, rsp_data.blue_out,
                                         head.rgb.blue_out));
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stalls, plus a hold-off counted down from hold_len whenever
   // the stimulus bumps hold_id. The hold-off is counted here, not in the sender.
   // -------------------------------------------------------------------------
   initial begin
      int seen_hold_id;
      int hold_left;
      seen_hold_id = 0;
      hold_left    = 0;
      rsp_stall    = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_id != seen_hold_id) begin
            seen_hold_id = hold_id;
            hold_left    = hold_len;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender helpers; every one is entered and left on a rising edge
   // -------------------------------------------------------------------------

   // Offer one pixel and hold it until the transfer happens
   task automatic send_pixel(input hsv_req_type px);
      pending_pixel_type entry;
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      entry.pixel = px;
      entry.rgb   = predict_rgb(px);
      pending_rgb.push_back(entry);
      pixels_sent++;
   endtask

   // Drop valid for one cycle
   task automatic idle_cycle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random pixels, with idle cycles drawn per cycle at send_idle_pct
   task automatic send_random_pixels(input int count);
      repeat (count) begin
         while ($urandom_range(99) < send_idle_pct) begin
            idle_cycle();
         end
         send_pixel(random_pixel());
      end
   endtask

   // Pause the sender until every predicted triple has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_rgb.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Corners: every sector, sector edges, hue at and past 360 degrees, the
   // largest hue word, grey, zero and unit levels
   task automatic test_corner_pixels();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_pixel(make_pixel(0, 255, 255));
      send_pixel(make_pixel(959, 255, 255));
      send_pixel(make_pixel(960, 255, 255));
      send_pixel(make_pixel(1919, 200, 255));
      send_pixel(make_pixel(1920, 255, 128));
      send_pixel(make_pixel(2880, 255, 255));
      send_pixel(make_pixel(3840, 255, 255));
      send_pixel(make_pixel(4800, 255, 255));
      send_pixel(make_pixel(5759, 255, 255));
      send_pixel(make_pixel(5760, 255, 255));
      send_pixel(make_pixel(5760, 128, 200));
      send_pixel(make_pixel(5761, 255, 255));
      send_pixel(make_pixel(6720, 255, 255));
      send_pixel(make_pixel(8191, 255, 255));
      send_pixel(make_pixel(480, 0, 255));
      send_pixel(make_pixel(8191, 0, 0));
      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel(480, 255, 0));
      send_pixel(make_pixel(480, 1, 255));
      send_pixel(make_pixel(3000, 255, 1));
      send_pixel(make_pixel(1234, 170, 85));
      send_pixel(make_pixel(4321, 85, 170));
      send_pixel(make_pixel(7000, 1, 1));
   endtask

   // Back-to-back transfers on both sides
   task automatic test_full_rate_stream();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_random_pixels(210);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct  = 55;
      recv_stall_pct = 0;
      send_random_pixels(180);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct  = 0;
      recv_stall_pct = 55;
      send_random_pixels(180);
   endtask

   task automatic test_gaps_and_stalls();
      send_idle_pct  = 36;
      recv_stall_pct = 36;
      send_random_pixels(180);
   endtask

   // Long output hold-off while the sender keeps offering: the pipeline fills
   // and must stall the request channel without losing or reordering pixels
   task automatic test_output_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_len       = 40;
      hold_id++;
      send_random_pixels(30);
      wait_for_drain();
      // Second hold-off lands on a mixed stream
      recv_stall_pct = 20;
      send_idle_pct  = 30;
      hold_len       = 25;
      hold_id++;
      send_random_pixels(60);
   endtask

   // -------------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_pixels();
      test_full_rate_stream();
      test_sender_gaps();
      test_receiver_stalls();
      test_gaps_and_stalls();
      test_output_hold_off();

      wait_for_drain();
      // Allow for the six pipeline stages in case anything stray follows
      repeat (12) @(posedge clock);

      if (pixels_checked != pixels_sent) begin
         report_mismatch($sformatf("sent %0d pixels but checked %0d",
                                   pixels_sent, pixels_checked));
      end

      $display("Run sent %0d and checked %0d pixels over every hue sector, hue at and",
               pixels_sent, pixels_checked);
      $display("past 360 degrees, grey and full saturation, idle/stall mixes; input",);
      $display("blocked %0d cycles.", blocked_cycles);
      if (error_count == 0) begin
         $display("PASS hsv_to_rgb_converter");
      end else begin
         $display("FAIL hsv_to_rgb_converter");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #1_000_000;
      $display("Timed out with %0d pixels outstanding", pending_rgb.size());
      $display("FAIL hsv_to_rgb_converter");
      $finish;
   end

endmodule
